### hw/rtl/ssa_pkg.sv
// Shared types, constants and helpers for the seek/arrive steering block.
`default_nettype none
package ssa_pkg;

  localparam int COORD_W  = 32;             // coordinate, velocity and force width
  localparam int DIFF_W   = COORD_W + 1;    // exact offset / offset magnitude
  localparam int SPEED_W  = 31;             // max_speed register width
  localparam int HALF_W   = 31;             // magnitude after range shift
  localparam int RAD_W    = 64;             // radicand, padded to an even width
  localparam int ROOT_W   = 32;             // floor(sqrt) width
  localparam int REM_W    = ROOT_W + 2;     // sqrt partial remainder
  localparam int DIST_W   = ROOT_W + 2;     // root shifted by up to two
  localparam int ARR_NUM_W = DIST_W + 4;    // span * 10
  localparam int ARR_DIV_W = 4;             // 3 * decel_factor
  localparam int PROD_W   = 64;             // |d| * speed
  localparam int QUOT_W   = 32;             // |d| * speed / span
  localparam int SPLIT_W  = 16;             // low slice of the partial products

  localparam logic REQ_SEEK   = 1'b0;
  localparam logic REQ_ARRIVE = 1'b1;
  localparam logic [1:0] DECEL_NONE = 2'd0;

  typedef struct packed {
    logic                        req_type;
    logic signed [COORD_W-1:0]   target_x;
    logic signed [COORD_W-1:0]   target_y;
    logic signed [COORD_W-1:0]   pos_x;
    logic signed [COORD_W-1:0]   pos_y;
    logic signed [COORD_W-1:0]   vel_x;
    logic signed [COORD_W-1:0]   vel_y;
    logic [1:0]                  decel_factor;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] force_x;
    logic signed [COORD_W-1:0] force_y;
  } steer_t;

  typedef logic [SPEED_W-1:0] cfg_t;

  // travels alongside the square root chain
  typedef struct packed {
    logic                      arrive;
    logic [1:0]                decel;
    logic [1:0]                shift;
    logic                      sx;
    logic                      sy;
    logic [DIFF_W-1:0]         mx;
    logic [DIFF_W-1:0]         my;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
  } sq_side_t;

  // travels alongside the arrive speed divider
  typedef struct packed {
    logic                      arrive;
    logic [1:0]                decel;
    logic [DIST_W-1:0]         span;
    logic                      sx;
    logic                      sy;
    logic [DIFF_W-1:0]         mx;
    logic [DIFF_W-1:0]         my;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
  } ar_side_t;

  // travels alongside the x-lane normalising divider
  typedef struct packed {
    logic                      arrive;
    logic                      sx;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
  } nx_side_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [COORD_W+2:0] v);
    logic signed [COORD_W+2:0] hi;
    logic signed [COORD_W+2:0] lo;
    hi = (COORD_W+3)'(64'sh7FFF_FFFF);
    lo = -(COORD_W+3)'(64'sh8000_0000);
    if (v > hi) begin
      return COORD_W'(hi);
    end else if (v < lo) begin
      return COORD_W'(lo);
    end
    return v[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ssa_stream_if.sv
// Valid/ready channel carrying one request or result payload.
`default_nettype none
interface ssa_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/ssa_sqrt_cell.sv
// One digit cell of the pipelined integer square root chain.
`default_nettype none
module ssa_sqrt_cell #(
  parameter type side_t = logic
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_vld,
  input  wire logic [ssa_pkg::REM_W-1:0]  in_rem,
  input  wire logic [ssa_pkg::ROOT_W-1:0] in_root,
  input  wire logic [ssa_pkg::RAD_W-1:0]  in_rad,
  input  wire side_t                      in_side,
  output logic                            out_vld,
  output logic [ssa_pkg::REM_W-1:0]       out_rem,
  output logic [ssa_pkg::ROOT_W-1:0]      out_root,
  output logic [ssa_pkg::RAD_W-1:0]       out_rad,
  output side_t                           out_side
);
  import ssa_pkg::*;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             take;

  assign rem_sh = {in_rem, in_rad[RAD_W-1 -: 2]};
  assign trial  = {2'b00, in_root, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      out_root <= {in_root[ROOT_W-2:0], take};
      out_rad  <= {in_rad[RAD_W-3:0], 2'b00};
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/ssa_div_cell.sv
// One quotient-bit cell of a pipelined restoring divider chain.
`default_nettype none
module ssa_div_cell #(
  parameter int  NUM_W  = 32,
  parameter int  DIV_W  = 34,
  parameter int  QW     = 32,
  parameter type side_t = logic
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [DIV_W-1:0] in_rem,
  input  wire logic [NUM_W-1:0] in_num,
  input  wire logic [DIV_W-1:0] in_div,
  input  wire logic [QW-1:0]    in_quo,
  input  wire side_t            in_side,
  output logic                  out_vld,
  output logic [DIV_W-1:0]      out_rem,
  output logic [NUM_W-1:0]      out_num,
  output logic [DIV_W-1:0]      out_div,
  output logic [QW-1:0]         out_quo,
  output side_t                 out_side
);
  logic [DIV_W:0] rem_sh;
  logic           take;

  assign rem_sh = {in_rem, in_num[NUM_W-1]};
  assign take   = (rem_sh >= {1'b0, in_div});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= take ? DIV_W'(rem_sh - {1'b0, in_div}) : rem_sh[DIV_W-1:0];
      out_num  <= {in_num[NUM_W-2:0], 1'b0};
      out_div  <= in_div;
      out_quo  <= {in_quo[QW-2:0], take};
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/steering_seek_arrive_core.sv
// Top level: seek/arrive steering force, fully pipelined chain of cells.
// Throughput: one request per cycle; a single advance enable moves every
//   stage, so the rate is set by the output register being free or taken.
// Reset (rst, synchronous): all stage valid flags clear, max_speed = 1.0.
// No clearing pass; the block accepts requests the cycle after reset.
`default_nettype none
module steering_seek_arrive_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  ssa_stream_if.sink    req,
  ssa_stream_if.sink    cfg,
  ssa_stream_if.source  steer
);
  import ssa_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration and flow control
  // ---------------------------------------------------------------------
  logic [SPEED_W-1:0] max_speed;
  logic               adv;
  logic               steer_vld;
  steer_t             steer_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= SPEED_W'(64'd1 << FRAC_BITS);
    end else if (cfg.valid) begin
      max_speed <= cfg.data;
    end
  end

  assign cfg.ready   = 1'b1;
  // whole pipe moves whenever the output register is free or being drained
  assign adv         = !steer_vld || steer.ready;
  assign req.ready   = adv;
  assign steer.valid = steer_vld;
  assign steer.data  = steer_data;

  // ---------------------------------------------------------------------
  // Stage 0: offset, magnitude, range shift
  // ---------------------------------------------------------------------
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        ax, ay;
  logic [1:0]               sh;
  logic                     s0_vld;
  sq_side_t                 s0_side;
  logic [HALF_W-1:0]        s0_a, s0_b;

  always_comb begin
    dx = {req.data.target_x[COORD_W-1], req.data.target_x}
       - {req.data.pos_x[COORD_W-1], req.data.pos_x};
    dy = {req.data.target_y[COORD_W-1], req.data.target_y}
       - {req.data.pos_y[COORD_W-1], req.data.pos_y};
    ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    // smallest shift that brings both magnitudes below 2^31
    if (ax[DIFF_W-1 -: 2] == 2'b00 && ay[DIFF_W-1 -: 2] == 2'b00) begin
      sh = 2'd0;
    end else if (!ax[DIFF_W-1] && !ay[DIFF_W-1]) begin
      sh = 2'd1;
    end else begin
      sh = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side.arrive <= (req.data.req_type == REQ_ARRIVE);
      s0_side.decel  <= req.data.decel_factor;
      s0_side.shift  <= sh;
      s0_side.sx     <= dx[DIFF_W-1];
      s0_side.sy     <= dy[DIFF_W-1];
      s0_side.mx     <= ax;
      s0_side.my     <= ay;
      s0_side.vx     <= req.data.vel_x;
      s0_side.vy     <= req.data.vel_y;
      s0_a           <= HALF_W'(ax >> sh);
      s0_b           <= HALF_W'(ay >> sh);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: squares; stage 2: radicand
  // ---------------------------------------------------------------------
  logic                  s1_vld, s2_vld;
  sq_side_t              s1_side, s2_side;
  logic [2*HALF_W-1:0]   s1_a2, s1_b2;
  logic [2*HALF_W:0]     s2_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s0_vld;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side <= s0_side;
      s1_a2   <= s0_a * s0_a;
      s1_b2   <= s0_b * s0_b;
      s2_side <= s1_side;
      s2_rad  <= {1'b0, s1_a2} + {1'b0, s1_b2};
    end
  end

  // ---------------------------------------------------------------------
  // Square root chain: one root bit per cell
  // ---------------------------------------------------------------------
  logic              sq_vld  [0:ROOT_W];
  logic [REM_W-1:0]  sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root [0:ROOT_W];
  logic [RAD_W-1:0]  sq_rad  [0:ROOT_W];
  sq_side_t          sq_side [0:ROOT_W];

  assign sq_vld[0]  = s2_vld;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = RAD_W'(s2_rad);
  assign sq_side[0] = s2_side;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    ssa_sqrt_cell #(.side_t(sq_side_t)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_vld   (sq_vld[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_rad   (sq_rad[i]),
      .in_side  (sq_side[i]),
      .out_vld  (sq_vld[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Distance and arrive numerator (dist * 10, divisor 3 * decel)
  // ---------------------------------------------------------------------
  logic                 ds_vld;
  ar_side_t             ds_side;
  logic [ARR_NUM_W-1:0] ds_num;
  logic [ARR_DIV_W-1:0] ds_div;
  logic [DIST_W-1:0]    dist_c;
  sq_side_t             sq_last;

  assign sq_last = sq_side[ROOT_W];
  assign dist_c  = DIST_W'(sq_root[ROOT_W]) << sq_last.shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      ds_vld <= 1'b0;
    end else if (adv) begin
      ds_vld <= sq_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_side.arrive <= sq_last.arrive;
      ds_side.decel  <= sq_last.decel;
      ds_side.span   <= dist_c;
      ds_side.sx     <= sq_last.sx;
      ds_side.sy     <= sq_last.sy;
      ds_side.mx     <= sq_last.mx;
      ds_side.my     <= sq_last.my;
      ds_side.vx     <= sq_last.vx;
      ds_side.vy     <= sq_last.vy;
      ds_num <= (ARR_NUM_W'(dist_c) << 3) + (ARR_NUM_W'(dist_c) << 1);
      ds_div <= (ARR_DIV_W'(sq_last.decel) << 1) + ARR_DIV_W'(sq_last.decel);
    end
  end

  // ---------------------------------------------------------------------
  // Arrive speed divider chain
  // ---------------------------------------------------------------------
  logic                 ar_vld  [0:ARR_NUM_W];
  logic [ARR_DIV_W-1:0] ar_rem  [0:ARR_NUM_W];
  logic [ARR_NUM_W-1:0] ar_num  [0:ARR_NUM_W];
  logic [ARR_DIV_W-1:0] ar_div  [0:ARR_NUM_W];
  logic [ARR_NUM_W-1:0] ar_quo  [0:ARR_NUM_W];
  ar_side_t             ar_side [0:ARR_NUM_W];

  assign ar_vld[0]  = ds_vld;
  assign ar_rem[0]  = '0;
  assign ar_num[0]  = ds_num;
  assign ar_div[0]  = ds_div;
  assign ar_quo[0]  = '0;
  assign ar_side[0] = ds_side;

  for (genvar i = 0; i < ARR_NUM_W; i++) begin : g_arr
    ssa_div_cell #(
      .NUM_W(ARR_NUM_W), .DIV_W(ARR_DIV_W), .QW(ARR_NUM_W), .side_t(ar_side_t)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_vld   (ar_vld[i]),
      .in_rem   (ar_rem[i]),
      .in_num   (ar_num[i]),
      .in_div   (ar_div[i]),
      .in_quo   (ar_quo[i]),
      .in_side  (ar_side[i]),
      .out_vld  (ar_vld[i+1]),
      .out_rem  (ar_rem[i+1]),
      .out_num  (ar_num[i+1]),
      .out_div  (ar_div[i+1]),
      .out_quo  (ar_quo[i+1]),
      .out_side (ar_side[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Speed select and cap
  // ---------------------------------------------------------------------
  logic               sp_vld;
  ar_side_t           sp_side;
  logic [SPEED_W-1:0] sp_speed;
  ar_side_t           ar_last;
  logic               use_max;

  assign ar_last = ar_side[ARR_NUM_W];
  assign use_max = !ar_last.arrive || (ar_last.decel == DECEL_NONE)
                || (ar_quo[ARR_NUM_W] > ARR_NUM_W'(max_speed));

  always_ff @(posedge clk) begin
    if (rst) begin
      sp_vld <= 1'b0;
    end else if (adv) begin
      sp_vld <= ar_vld[ARR_NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_side  <= ar_last;
      sp_speed <= use_max ? max_speed : ar_quo[ARR_NUM_W][SPEED_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // |d| * speed in two slices, then recombined
  // ---------------------------------------------------------------------
  localparam int HI_W = DIFF_W - SPLIT_W;

  logic                              m1_vld, m2_vld;
  ar_side_t                          m1_side, m2_side;
  logic [SPLIT_W+SPEED_W-1:0]        m1_lo_x, m1_lo_y;
  logic [HI_W+SPEED_W-1:0]           m1_hi_x, m1_hi_y;
  logic [PROD_W-1:0]                 m2_num_x, m2_num_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
    end else if (adv) begin
      m1_vld <= sp_vld;
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_side  <= sp_side;
      m1_lo_x  <= sp_side.mx[SPLIT_W-1:0] * sp_speed;
      m1_hi_x  <= sp_side.mx[DIFF_W-1:SPLIT_W] * sp_speed;
      m1_lo_y  <= sp_side.my[SPLIT_W-1:0] * sp_speed;
      m1_hi_y  <= sp_side.my[DIFF_W-1:SPLIT_W] * sp_speed;
      m2_side  <= m1_side;
      m2_num_x <= (PROD_W'(m1_hi_x) << SPLIT_W) + PROD_W'(m1_lo_x);
      m2_num_y <= (PROD_W'(m1_hi_y) << SPLIT_W) + PROD_W'(m1_lo_y);
    end
  end

  // ---------------------------------------------------------------------
  // Normalising dividers, one lane per axis: |d| * speed / span
  // The top half of the product seeds the remainder; it is below span.
  // ---------------------------------------------------------------------
  logic               nx_vld  [0:QUOT_W];
  logic [DIST_W-1:0]  nx_rem  [0:QUOT_W];
  logic [QUOT_W-1:0]  nx_num  [0:QUOT_W];
  logic [DIST_W-1:0]  nx_div  [0:QUOT_W];
  logic [QUOT_W-1:0]  nx_quo  [0:QUOT_W];
  nx_side_t           nx_side [0:QUOT_W];
  logic               ny_vld  [0:QUOT_W];
  logic [DIST_W-1:0]  ny_rem  [0:QUOT_W];
  logic [QUOT_W-1:0]  ny_num  [0:QUOT_W];
  logic [DIST_W-1:0]  ny_div  [0:QUOT_W];
  logic [QUOT_W-1:0]  ny_quo  [0:QUOT_W];
  logic               ny_side [0:QUOT_W];

  assign nx_vld[0]         = m2_vld;
  assign nx_rem[0]         = DIST_W'(m2_num_x[PROD_W-1:QUOT_W]);
  assign nx_num[0]         = m2_num_x[QUOT_W-1:0];
  assign nx_div[0]         = m2_side.span;
  assign nx_quo[0]         = '0;
  assign nx_side[0].arrive = m2_side.arrive;
  assign nx_side[0].sx     = m2_side.sx;
  assign nx_side[0].vx     = m2_side.vx;
  assign nx_side[0].vy     = m2_side.vy;
  assign ny_vld[0]         = m2_vld;
  assign ny_rem[0]         = DIST_W'(m2_num_y[PROD_W-1:QUOT_W]);
  assign ny_num[0]         = m2_num_y[QUOT_W-1:0];
  assign ny_div[0]         = m2_side.span;
  assign ny_quo[0]         = '0;
  assign ny_side[0]        = m2_side.sy;

  for (genvar i = 0; i < QUOT_W; i++) begin : g_norm
    ssa_div_cell #(
      .NUM_W(QUOT_W), .DIV_W(DIST_W), .QW(QUOT_W), .side_t(nx_side_t)
    ) u_x (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_vld   (nx_vld[i]),
      .in_rem   (nx_rem[i]),
      .in_num   (nx_num[i]),
      .in_div   (nx_div[i]),
      .in_quo   (nx_quo[i]),
      .in_side  (nx_side[i]),
      .out_vld  (nx_vld[i+1]),
      .out_rem  (nx_rem[i+1]),
      .out_num  (nx_num[i+1]),
      .out_div  (nx_div[i+1]),
      .out_quo  (nx_quo[i+1]),
      .out_side (nx_side[i+1])
    );
    ssa_div_cell #(
      .NUM_W(QUOT_W), .DIV_W(DIST_W), .QW(QUOT_W), .side_t(logic)
    ) u_y (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_vld   (ny_vld[i]),
      .in_rem   (ny_rem[i]),
      .in_num   (ny_num[i]),
      .in_div   (ny_div[i]),
      .in_quo   (ny_quo[i]),
      .in_side  (ny_side[i]),
      .out_vld  (ny_vld[i+1]),
      .out_rem  (ny_rem[i+1]),
      .out_num  (ny_num[i+1]),
      .out_div  (ny_div[i+1]),
      .out_quo  (ny_quo[i+1]),
      .out_side (ny_side[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Output: apply sign, subtract velocity, saturate
  // Zero offset: arrive gives (0,0); seek wants zero velocity.
  // ---------------------------------------------------------------------
  nx_side_t                   nl;
  logic                       zero_off;
  logic signed [DIFF_W:0]     wx, wy;
  logic signed [COORD_W+2:0]  fx, fy;
  steer_t                     steer_next;
  logic                       ny_unused_vld;

  assign nl            = nx_side[QUOT_W];
  assign zero_off      = (nx_div[QUOT_W] == '0);
  assign ny_unused_vld = ny_vld[QUOT_W];

  always_comb begin
    wx = nl.sx ? -(DIFF_W+1)'(nx_quo[QUOT_W]) : (DIFF_W+1)'(nx_quo[QUOT_W]);
    wy = ny_side[QUOT_W] ? -(DIFF_W+1)'(ny_quo[QUOT_W])
                         : (DIFF_W+1)'(ny_quo[QUOT_W]);
    if (zero_off) begin
      wx = '0;
      wy = '0;
    end
    fx = (COORD_W+3)'(wx) - (COORD_W+3)'(nl.vx);
    fy = (COORD_W+3)'(wy) - (COORD_W+3)'(nl.vy);
    steer_next.force_x = sat32(fx);
    steer_next.force_y = sat32(fy);
    if (zero_off && nl.arrive) begin
      steer_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_vld <= 1'b0;
    end else if (adv) begin
      steer_vld <= nx_vld[QUOT_W] && ny_unused_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      steer_data <= steer_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_speed: assert property (@(posedge clk)
    $past(rst) && !$past(cfg.valid) |-> max_speed == SPEED_W'(64'd1 << FRAC_BITS))
    else $error("max_speed not at reset value");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> s0_vld)
    else $error("accepted request did not enter the pipe");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    nx_vld[QUOT_W] == ny_vld[QUOT_W])
    else $error("x and y divider lanes out of step");

  a_arrive_zero: assert property (@(posedge clk) disable iff (rst)
    adv && nx_vld[QUOT_W] && zero_off && nl.arrive |=> steer_data == '0)
    else $error("arrive at target gave non-zero force");
`endif
endmodule
`default_nettype wire

### sim/steering_seek_arrive_core_tb.sv
// Self-checking testbench for the seek/arrive steering core.
`timescale 1ns / 1ps
module steering_seek_arrive_core_tb;
  import ssa_pkg::*;

  // ---------------------------------------------------------------------
  // Clock, reset and the three channels
  // ---------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  ssa_stream_if #(.payload_t(req_t))   req_ch ();
  ssa_stream_if #(.payload_t(cfg_t))   cfg_ch ();
  ssa_stream_if #(.payload_t(steer_t)) steer_ch ();

  steering_seek_arrive_core dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req_ch.sink),
    .cfg   (cfg_ch.sink),
    .steer (steer_ch.source)
  );

  localparam int LATENCY = 110;

  // ---------------------------------------------------------------------
  // Shared state between stimulus, driver and monitor
  // ---------------------------------------------------------------------
  req_t   pending_reqs[$];    // requests waiting to be driven
  steer_t expected_forces[$]; // forces predicted for accepted requests
  cfg_t   speed_cap;          // testbench copy of max_speed
  int     mismatches = 0;
  bit     quiet_phase = 1'b0; // no idling on either side
  bit     hold_off = 1'b0;    // long sink stall requested
  int     gap_left = 0;
  int     stall_left = 0;

  // ---------------------------------------------------------------------
  // Force predictor: offset, length by integer root, speed, then
  // desired velocity less current velocity with 32-bit saturation.
  // ---------------------------------------------------------------------
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_force(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint scaled_component(input longint d,
      input longint unsigned speed, input longint unsigned span);
    longint unsigned m;
    m = ((d < 0 ? -d : d) * speed) / span;
    return d < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic steer_t predict_force(input req_t r);
    longint dx, dy, wx, wy;
    longint unsigned ax, ay, a, b, span, speed;
    int sh;
    steer_t f;
    dx = longint'(r.target_x) - longint'(r.pos_x);
    dy = longint'(r.target_y) - longint'(r.pos_y);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    sh = 0;
    while (sh < 2 && ((ax >> sh) >= 64'h8000_0000 || (ay >> sh) >= 64'h8000_0000)) sh++;
    a = ax >> sh;
    b = ay >> sh;
    span = root_floor(a * a + b * b) << sh;
    wx = 0;
    wy = 0;
    if (span == 0) begin
      // zero offset: arrive stops dead, seek just cancels the velocity
      if (r.req_type == REQ_ARRIVE) begin
        f.force_x = '0;
        f.force_y = '0;
        return f;
      end
    end else begin
      speed = speed_cap;
      if (r.req_type == REQ_ARRIVE && r.decel_factor != DECEL_NONE) begin
        speed = (span * 10) / (3 * r.decel_factor);
        if (speed > speed_cap) speed = speed_cap;
      end
      wx = scaled_component(dx, speed, span);
      wy = scaled_component(dy, speed, span);
    end
    f.force_x = clamp_force(wx - longint'(r.vel_x));
    f.force_y = clamp_force(wy - longint'(r.vel_y));
    return f;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: pops the queue, idles in random bursts
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_forces.push_back(predict_force(req_ch.data));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(1, 11) - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_ch.data <= pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor and sink stalls
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    steer_t exp_f;
    if (rst) begin
      steer_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (steer_ch.valid && steer_ch.ready) begin
        if (expected_forces.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", steer_ch.data);
        end else begin
          exp_f = expected_forces.pop_front();
          if (steer_ch.data.force_x !== exp_f.force_x ||
              steer_ch.data.force_y !== exp_f.force_y) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("force mismatch: expected (%0d, %0d) got (%0d, %0d)",
                       exp_f.force_x, exp_f.force_y,
                       steer_ch.data.force_x, steer_ch.data.force_y);
          end
        end
      end
      if (hold_off) begin
        steer_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        steer_ch.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 11) - 1;
        steer_ch.ready <= 1'b0;
      end else begin
        steer_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h000F_FFFF)
                                     : -$urandom_range(0, 32'h000F_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.req_type = $urandom_range(0, 1) ? REQ_ARRIVE : REQ_SEEK;
    r.target_x = rand_coord();
    r.target_y = rand_coord();
    // a near target keeps arrive off the speed cap now and then
    if ($urandom_range(0, 3) == 0) begin
      r.pos_x = r.target_x + $signed($urandom_range(0, 16'hFFFF) - 16'h7FFF);
      r.pos_y = r.target_y + $signed($urandom_range(0, 16'hFFFF) - 16'h7FFF);
    end else begin
      r.pos_x = rand_coord();
      r.pos_y = rand_coord();
    end
    if ($urandom_range(0, 15) == 0) begin
      r.pos_x = r.target_x;
      r.pos_y = r.target_y;
    end
    r.vel_x = rand_coord();
    r.vel_y = rand_coord();
    r.decel_factor = 2'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic req_t make_req(input logic op, input logic [31:0] tx, ty,
      px, py, vx, vy, input logic [1:0] dec);
    req_t r;
    r.req_type = op; r.target_x = tx; r.target_y = ty;
    r.pos_x = px; r.pos_y = py; r.vel_x = vx; r.vel_y = vy;
    r.decel_factor = dec;
    return r;
  endfunction

  // Only called when the block is empty; it does not wait for in-flight work.
  task automatic write_speed(input cfg_t v);
    @(posedge clk);
    cfg_ch.data <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    speed_cap = v;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_forces.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  initial begin
    cfg_t speeds[5];
    speeds = '{31'h0001_0000, 31'd0, 31'h7FFF_FFFF, 31'h0000_8000, 31'h0123_4567};
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    steer_ch.ready = 1'b0;
    speed_cap = 31'h0001_0000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, both operations, zero offset, decel levels
    pending_reqs.push_back(make_req(REQ_SEEK, ONE, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_SEEK, 0, 0, 0, 0, MINV, MINV, 1));
    pending_reqs.push_back(make_req(REQ_SEEK, 5, 5, 5, 5, MAXV, 1, 2));
    pending_reqs.push_back(make_req(REQ_ARRIVE, 7, 7, 7, 7, MINV, MAXV, 3));
    pending_reqs.push_back(make_req(REQ_SEEK, MAXV, MAXV, MINV, MINV, MAXV, MINV, 0));
    pending_reqs.push_back(make_req(REQ_SEEK, MINV, MINV, MAXV, MAXV, MINV, MAXV, 3));
    pending_reqs.push_back(make_req(REQ_ARRIVE, MAXV, MINV, MINV, MAXV, 0, 0, 1));
    pending_reqs.push_back(make_req(REQ_ARRIVE, MAXV, 0, MINV, 0, MAXV, MINV, 2));
    for (int k = 0; k < 4; k++) begin
      pending_reqs.push_back(make_req(REQ_ARRIVE, 32'h0000_4000, 0, 0, 0, 0, 0, 2'(k)));
      pending_reqs.push_back(make_req(REQ_ARRIVE, 0, -32'sd300000, 0, 0, ONE, -ONE,
                                      2'(k)));
    end
    pending_reqs.push_back(make_req(REQ_SEEK, 1, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_SEEK, 0, MAXV, 0, MINV, 0, 0, 0));
    drain();

    // random phases, one per max_speed setting, reset value included
    for (int ph = 0; ph < 5; ph++) begin
      write_speed(speeds[ph]);
      for (int i = 0; i < 110; i++) pending_reqs.push_back(rand_req());
      if (ph == 1) begin
        // back-pressure: sink holds off while the source keeps offering
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    // closing stretch without idling
    quiet_phase = 1'b1;
    write_speed(31'($urandom_range(1, 31'h7FFF_FFFF)));
    for (int i = 0; i < 80; i++) pending_reqs.push_back(rand_req());
    drain();

    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### steering_seek_arrive_core.f
hw/rtl/ssa_pkg.sv
hw/rtl/ssa_stream_if.sv
hw/rtl/ssa_sqrt_cell.sv
hw/rtl/ssa_div_cell.sv
hw/rtl/steering_seek_arrive_core.sv
sim/steering_seek_arrive_core_tb.sv
